>>> rtl/integer_to_ascii_radix_core_defines.svh
// Assertion macros for the integer to ASCII radix converter.
// Used by the top level; expects clk and arst_n in scope.
`ifndef INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH

// property must hold at every clock edge outside reset
`define ITAR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ITAR_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

>>> rtl/itar_pkg.sv
// Shared constants, types and helpers of the integer to ASCII radix converter.
// No dependencies.
package itar_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int RADIX_W        = 6;
	localparam int CHAR_W         = 8;
	localparam int DIGIT_W        = 6;
	localparam int DIV_STEPS      = 8;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX_NUM = 6'd9;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h61;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	// back end status seen by the top level
	typedef struct packed {
		logic div_busy;
		logic pop_busy;
		logic stk_empty;
		logic stk_over;
	} itar_stat_t;

	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] b;
		b = r;
		if (r < RADIX_MIN) begin
			b = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			b = RADIX_MAX;
		end
		return b;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d > DIGIT_MAX_NUM) begin
			c = CH_ALPHA + CHAR_W'(d - RADIX_DEC);
		end else begin
			c = CH_ZERO + CHAR_W'(d);
		end
		return c;
	endfunction

endpackage

>>> rtl/integer_to_ascii_radix_core.sv
// Integer to ASCII radix converter, top level: front end, job queue, back end.
// Depends on itar_pkg, itar_front, itar_queue, itar_back and the defines header.
//
// Each pushed item is a signed value and a radix (clamped to 2..36); the
// block pops out its ASCII digits, most significant first, '0'-'9' then
// 'a'-'z', with last set on the final character and no terminator. Zero
// gives a single '0'. In radix ten a negative value is preceded by '-' and
// its magnitude (the most negative value included) follows; any other radix
// reads the bits as an unsigned VALUE_BITS-bit number. Timing: the front end
// takes an item per cycle while full is low, into a two-entry queue. The
// back end picks up a job, runs its divider once per digit (8 quotient
// bits per cycle), loads a sign if there is one, then hands out one
// character per pop. The divider loop sets the rate; the output register
// lets the next item's division overlap a stalled pop only for the last
// held character, so slow pops slow the block.
`include "integer_to_ascii_radix_core_defines.svh"

module integer_to_ascii_radix_core import itar_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic        [RADIX_W-1:0]    radix,
	output logic                         empty,
	input  logic                         pop,
	output logic        [CHAR_W-1:0]     character,
	output logic                         last
);

	localparam int JOB_W = VALUE_BITS + RADIX_W + 1;

	// front to queue
	logic                  f_valid;
	logic                  q_not_full;
	logic [VALUE_BITS-1:0] f_mag;
	logic [RADIX_W-1:0]    f_base;
	logic                  f_neg;

	// queue to back
	logic                  q_valid;
	logic                  b_take;
	logic [JOB_W-1:0]      q_data;

	itar_stat_t            stat;

	itar_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.value    (value),
		.radix    (radix),
		.job_valid(f_valid),
		.job_ready(q_not_full),
		.job_mag  (f_mag),
		.job_base (f_base),
		.job_neg  (f_neg)
	);

	itar_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_valid),
		.wr_data ({f_mag, f_base, f_neg}),
		.not_full(q_not_full),
		.rd_valid(q_valid),
		.rd_en   (b_take),
		.rd_data (q_data)
	);

	itar_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(q_valid),
		.job_take (b_take),
		.job_mag  (q_data[JOB_W-1 -: VALUE_BITS]),
		.job_base (q_data[RADIX_W:1]),
		.job_neg  (q_data[0]),
		.empty    (empty),
		.pop      (pop),
		.character(character),
		.last     (last),
		.stat     (stat)
	);

	// assertions
	`ITAR_NEVER(a_stk_over, stat.stk_over, "digit stack holds more digits than value bits")
	`ITAR_ASSERT(a_pop_has_digit, stat.pop_busy |-> !stat.stk_empty, "emit phase with empty stack")
	`ITAR_ASSERT(a_minus_not_last, (!empty && character == CH_MINUS) |-> !last, "sign flagged last")
	`ITAR_ASSERT(a_div_stack_room, stat.div_busy |-> !stat.stk_over, "division with full stack")

endmodule

>>> rtl/itar_front.sv
// Front end: accepts an item, clamps the radix and forms the magnitude and sign.
// Depends on itar_pkg.
module itar_front import itar_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic        [RADIX_W-1:0]    radix,
	output logic                         job_valid,
	input  logic                         job_ready,
	output logic        [VALUE_BITS-1:0] job_mag,
	output logic        [RADIX_W-1:0]    job_base,
	output logic                         job_neg
);

	logic                  valid_s1;
	logic [VALUE_BITS-1:0] mag_s1;
	logic [RADIX_W-1:0]    base_s1;
	logic                  neg_s1;

	logic                  take;
	logic [VALUE_BITS-1:0] uval;
	logic [RADIX_W-1:0]    base_c;
	logic                  neg_c;
	logic [VALUE_BITS-1:0] mag_c;

	assign full = valid_s1 && !job_ready;
	assign take = push && !full;

	assign uval   = value;
	assign base_c = clamp_radix(radix);
	// only decimal carries a sign; the most negative value negates to itself,
	// which read unsigned is the true magnitude
	assign neg_c  = (base_c == RADIX_DEC) && uval[VALUE_BITS-1];
	assign mag_c  = neg_c ? (~uval + VALUE_BITS'(1)) : uval;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !job_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mag_s1  <= mag_c;
			base_s1 <= base_c;
			neg_s1  <= neg_c;
		end
	end

	assign job_valid = valid_s1;
	assign job_mag   = mag_s1;
	assign job_base  = base_s1;
	assign job_neg   = neg_s1;

endmodule

>>> rtl/itar_queue.sv
// Short job queue between front and back end.
// Depends on itar_pkg.
module itar_queue import itar_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             not_full,
	output logic             rd_valid,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign not_full = (cnt_q != CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign do_wr    = wr_en && not_full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> rtl/itar_back.sv
// Back end: iterative divider by the radix, digit stack, sign and output register.
// Depends on itar_pkg.
module itar_back import itar_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	output logic                  job_take,
	input  logic [VALUE_BITS-1:0] job_mag,
	input  logic [RADIX_W-1:0]    job_base,
	input  logic                  job_neg,
	output logic                  empty,
	input  logic                  pop,
	output logic [CHAR_W-1:0]     character,
	output logic                  last,
	output itar_stat_t            stat
);

	localparam int ITER = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam int PW   = ITER * DIV_STEPS;
	localparam int CW   = $clog2(ITER + 1);
	localparam int SPW  = $clog2(VALUE_BITS + 1);

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_DIV  = 4'b0010,
		B_SIGN = 4'b0100,
		B_POP  = 4'b1000
	} back_state_t;

	back_state_t state_q, state_nx;

	logic [PW-1:0]      num_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [RADIX_W-1:0] base_q;
	logic               neg_q;
	logic [CW-1:0]      cnt_q;
	logic [SPW-1:0]     sp_q;
	logic [DIGIT_W-1:0] stk_q [VALUE_BITS];
	logic               out_v_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic [RADIX_W:0]   rem_w;
	logic [PW-1:0]      num_w;
	logic               slot_free;
	logic               div_done;
	logic               push_stk;
	logic               pop_stk;
	logic               load_sign;

	// restoring division, DIV_STEPS quotient bits per cycle; dividend bits
	// leave at the top while quotient bits enter at the bottom
	always_comb begin
		rem_w = {1'b0, rem_q};
		num_w = num_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			rem_w = {rem_w[RADIX_W-1:0], num_w[PW-1]};
			num_w = {num_w[PW-2:0], 1'b0};
			if (rem_w >= {1'b0, base_q}) begin
				rem_w    = rem_w - {1'b0, base_q};
				num_w[0] = 1'b1;
			end
		end
	end

	assign slot_free = !out_v_q || pop;
	assign div_done  = (state_q == B_DIV) && (cnt_q == CW'(ITER - 1));
	assign push_stk  = div_done;
	assign pop_stk   = (state_q == B_POP) && slot_free;
	assign load_sign = (state_q == B_SIGN) && slot_free;
	assign job_take  = (state_q == B_IDLE) && job_valid;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					state_nx = B_DIV;
				end
			end
			B_DIV: begin
				if (div_done && (num_w == '0)) begin
					state_nx = neg_q ? B_SIGN : B_POP;
				end
			end
			B_SIGN: begin
				if (slot_free) begin
					state_nx = B_POP;
				end
			end
			B_POP: begin
				if (slot_free && (sp_q == SPW'(1))) begin
					state_nx = B_IDLE;
				end
			end
			default: state_nx = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= '0;
			sp_q    <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (job_take || div_done) begin
				cnt_q <= '0;
			end else if (state_q == B_DIV) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (push_stk) begin
				sp_q <= sp_q + SPW'(1);
			end else if (pop_stk) begin
				sp_q <= sp_q - SPW'(1);
			end
			if (pop_stk || load_sign) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			num_q  <= PW'(job_mag);
			rem_q  <= '0;
			base_q <= job_base;
			neg_q  <= job_neg;
		end else if (state_q == B_DIV) begin
			num_q <= num_w;
			rem_q <= div_done ? '0 : rem_w[DIGIT_W-1:0];
		end
		// digits come out least significant first; the stack turns them round
		if (push_stk) begin
			stk_q[0] <= rem_w[DIGIT_W-1:0];
			for (int i = 1; i < VALUE_BITS; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end else if (pop_stk) begin
			for (int i = 0; i < VALUE_BITS - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
		end
		if (load_sign) begin
			char_q <= CH_MINUS;
			last_q <= 1'b0;
		end else if (pop_stk) begin
			char_q <= digit_char(stk_q[0]);
			last_q <= (sp_q == SPW'(1));
		end
	end

	assign empty     = !out_v_q;
	assign character = char_q;
	assign last      = last_q;

	assign stat.div_busy  = (state_q == B_DIV);
	assign stat.pop_busy  = (state_q == B_POP);
	assign stat.stk_empty = (sp_q == '0);
	assign stat.stk_over  = (sp_q > SPW'(VALUE_BITS));

endmodule

>>> tb/sv/itar_char_checker.sv
// Checker for the integer to ASCII radix converter: predicts the characters
// of every accepted request and compares each popped character against them.
// Depends on itar_pkg only.
module itar_char_checker import itar_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [RADIX_W-1:0]    radix,
	input  logic                  empty,
	input  logic                  pop,
	input  logic [CHAR_W-1:0]     character,
	input  logic                  last,
	output int                    mismatch_count,
	output int                    pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [CHAR_W-1:0] code;
		logic              fin;
	} char_exp_t;

	char_exp_t expected_chars[$];

	initial begin
		mismatch_count = 0;
		pending_count  = 0;
	end

	// append the characters one request should produce
	function automatic void predict_chars(input logic [VALUE_BITS-1:0] v,
			input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0]    base;
		logic [VALUE_BITS-1:0] mag;
		logic [CHAR_W-1:0]     dval;
		logic [CHAR_W-1:0]     digs[$];
		logic                  neg;
		base = r;
		if (r < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			base = RADIX_MAX;
		end
		if (v == '0) begin
			expected_chars.push_back('{code: CH_ZERO, fin: 1'b1});
			return;
		end
		// only decimal is signed; the magnitude wraps correctly for the most negative value
		neg = (base == RADIX_DEC) && v[VALUE_BITS-1];
		mag = neg ? -v : v;
		while (mag != '0) begin
			dval = CHAR_W'(mag % VALUE_BITS'(base));
			if (dval > CHAR_W'(DIGIT_MAX_NUM)) begin
				digs.push_front(CH_ALPHA + dval - CHAR_W'(RADIX_DEC));
			end else begin
				digs.push_front(CH_ZERO + dval);
			end
			mag = mag / VALUE_BITS'(base);
		end
		if (neg) begin
			expected_chars.push_back('{code: CH_MINUS, fin: 1'b0});
		end
		foreach (digs[i]) begin
			expected_chars.push_back('{code: digs[i], fin: (i == digs.size() - 1)});
		end
	endfunction

	always @(posedge clk) begin
		char_exp_t want;
		if (arst_n) begin
			if (push && !full) begin
				predict_chars(value, radix);
			end
			if (pop && !empty) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected character %h, last %b", character, last);
					mismatch_count++;
				end else begin
					want = expected_chars.pop_front();
					if (character !== want.code) begin
						$error("character: expected %h, actual %h", want.code, character);
						mismatch_count++;
					end
					if (last !== want.fin) begin
						$error("last: expected %b, actual %b", want.fin, last);
						mismatch_count++;
					end
				end
			end
		end
		pending_count <= expected_chars.size();
	end

endmodule

>>> tb/sv/tb.sv
// Testbench top for integer_to_ascii_radix_core: clock, reset, request and
// pop stimulus, and the verdict. Depends on itar_pkg, the core and itar_char_checker.
module tb;
	import itar_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VB = VALUE_BITS_DEF;
	// this limit only catches a hang
	localparam int CYCLE_LIMIT = 1000000;
	// long pop hold-off so the job queue fills and full rises
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_REQUESTS = 178;
	localparam int CALM_REQUESTS = 40;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic signed [VB-1:0]  value = '0;
	logic [RADIX_W-1:0]    radix = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [CHAR_W-1:0]     character;
	logic                  last;

	int          mismatch_count;
	int          pending_count;
	int unsigned cycle_count = 0;
	bit          calm = 1'b0;     // no idling on either side
	logic        hold_pop = 1'b0; // asks the pop side for one long hold-off

	integer_to_ascii_radix_core #(
		.VALUE_BITS(VB)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.value(value),
		.radix(radix),
		.empty(empty),
		.pop(pop),
		.character(character),
		.last(last)
	);

	itar_char_checker #(
		.VALUE_BITS(VB)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.value(value),
		.radix(radix),
		.empty(empty),
		.pop(pop),
		.character(character),
		.last(last),
		.mismatch_count(mismatch_count),
		.pending_count(pending_count)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// hang guard
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offer one request and hold it until the core takes it. push stays high
	// when no gap follows, so back-to-back requests never toggle it within a step.
	task automatic send_request(input logic [VB-1:0] v, input logic [RADIX_W-1:0] r);
		push  <= 1'b1;
		value <= v;
		radix <= r;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		if (!calm && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// mix of wide, short, negative and boundary values
	function automatic logic [VB-1:0] pick_value();
		logic [VB-1:0] v;
		case ($urandom_range(0, 5))
			0: v = VB'($urandom_range(0, 40));
			1: v = -VB'($urandom_range(1, 1000));
			2: v = VB'($urandom) >> $urandom_range(0, VB - 1);
			3: begin
				case ($urandom_range(0, 4))
					0: v = '0;
					1: v = '1;
					2: v = {1'b1, {(VB-1){1'b0}}};
					3: v = {1'b0, {(VB-1){1'b1}}};
					default: v = VB'(1);
				endcase
			end
			default: v = VB'($urandom);
		endcase
		return v;
	endfunction

	// mostly legal radixes, decimal often for the sign path, sometimes out of range
	function automatic logic [RADIX_W-1:0] pick_radix();
		logic [RADIX_W-1:0] r;
		case ($urandom_range(0, 4))
			0: r = RADIX_DEC;
			1: r = RADIX_W'($urandom_range(0, 63));
			default: r = RADIX_W'($urandom_range(2, 36));
		endcase
		return r;
	endfunction

	// Pop side: random stall bursts, plus the one long hold-off, counted here,
	// when hold_pop rises.
	initial begin
		int stall_left;
		int hold_left;
		bit hold_done;
		stall_left = 0;
		hold_left  = 0;
		hold_done  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pop && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero in several radixes, sign handling, extremes, clamping, letters
		send_request('0, RADIX_DEC);
		send_request('0, RADIX_MIN);
		send_request('0, RADIX_MAX);
		send_request('1, RADIX_DEC);
		send_request('1, 6'd16);
		send_request('1, RADIX_MIN);
		send_request({1'b1, {(VB-1){1'b0}}}, RADIX_DEC);
		send_request({1'b1, {(VB-1){1'b0}}}, RADIX_MIN);
		send_request({1'b0, {(VB-1){1'b1}}}, RADIX_DEC);
		send_request({1'b0, {(VB-1){1'b1}}}, RADIX_MAX);
		send_request(VB'(255), 6'd16);
		send_request(VB'(35), RADIX_MAX);
		send_request(VB'(10), 6'd11);
		send_request(VB'(123), 6'd0);
		send_request(VB'(123), 6'd1);
		send_request(VB'(123456), 6'd37);
		send_request(-VB'(77), 6'd63);
		send_request(VB'(83), 6'd8);
		send_request(-VB'(12345), RADIX_DEC);
		send_request(-VB'(5), 6'd3);
		send_request(VB'(1), RADIX_MIN);
		send_request(VB'(9), RADIX_DEC);

		// pressure: pop side holds off while requests keep coming, so full must rise
		hold_pop <= 1'b1;
		repeat (10) begin
			send_request(pick_value(), pick_radix());
		end

		// random requests; the final stretch runs with no idling
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i == RANDOM_REQUESTS - CALM_REQUESTS) begin
				calm = 1'b1;
			end
			send_request(pick_value(), pick_radix());
		end
		push <= 1'b0;

		while (pending_count != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/itar_pkg.sv
rtl/itar_front.sv
rtl/itar_queue.sv
rtl/itar_back.sv
rtl/integer_to_ascii_radix_core.sv
tb/sv/itar_char_checker.sv
tb/sv/tb.sv
